FILE: rtl/lcar_pkg.sv
`default_nettype none

package lcar_pkg;

  // Element width and stream depth.
  localparam int VALUE_BITS = 16;
  localparam int MAX_LENGTH = 1024;

  // Position of an element inside the stream, and the counter that can also hold MAX_LENGTH.
  localparam int POS_BITS = $clog2(MAX_LENGTH);
  localparam int IDX_BITS = $clog2(MAX_LENGTH + 1);

  // Width of the reported indices and of the padded result data bus.
  localparam int RUN_BITS   = 10;
  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * RUN_BITS + 7) / 8) * 8;

  // Result of the shared gcd unit.
  typedef struct packed {
    logic done;
    logic coprime;
  } gcd_res_t;

endpackage

`default_nettype wire

FILE: rtl/longest_coprime_adjacent_run.sv
`default_nettype none

// Longest run of coprime neighbors in a stream of positive integers.
// Input channel: one element per item, value in in_tdata[15:0], in_tlast on the
// final element of a stream. Result channel: one item per stream, produced after
// the element carrying in_tlast, with the start and end index of the earliest
// longest run whose neighbor pairs all have gcd 1 (0 and 0 if there is none),
// and out_tuser set if the stream had more than 1024 elements.
// Every neighbor pair goes through one shared binary gcd unit that removes one
// factor of two or does one subtraction per cycle. The first element of a
// stream (and any element past 1024) goes straight to the run search update;
// any other element first waits for the gcd unit and is then folded in. The
// result of a final element is handed over to the output register.
// One item is worked on at a time: in_tready is low while an element is in the
// gcd unit or being folded into the run search, and while a result waits in
// the output register. If the receiver stalls, the result stays there and no
// new element is taken until out_tready takes it.
// Reset (rst_n low at a clock edge) clears the run search state and drops any
// pending result; the block is ready in the cycle after the reset edge.
module longest_coprime_adjacent_run (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [lcar_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] value
  input  wire logic                             in_tlast,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [lcar_pkg::OUT_TDATA_W-1:0] out_tdata,  // [9:0] run_start, [19:10] run_end
  output      logic                             out_tuser   // overflow
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_GCD  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic [lcar_pkg::VALUE_BITS-1:0]   value_r;
  logic                              last_r;
  logic                              coprime_r;
  logic [lcar_pkg::VALUE_BITS-1:0]   prev_r, prev_nxt;
  logic [lcar_pkg::IDX_BITS-1:0]     idx_r, idx_nxt;
  logic [lcar_pkg::POS_BITS-1:0]     cur_start_r, cur_start_nxt;
  logic [lcar_pkg::POS_BITS-1:0]     best_start_r, best_start_nxt;
  logic [lcar_pkg::POS_BITS-1:0]     best_end_r, best_end_nxt;
  logic [lcar_pkg::POS_BITS-1:0]     best_len_r, best_len_nxt;
  logic                              exceeded_r, exceeded_nxt;
  logic                              out_valid_r;
  logic [lcar_pkg::RUN_BITS-1:0]     out_start_r, out_end_r;
  logic                              out_ovf_r;
  logic                              in_acc;
  logic                              in_range;
  logic                              need_gcd;
  logic [lcar_pkg::POS_BITS-1:0]     pos;
  logic [lcar_pkg::POS_BITS-1:0]     run_len;
  lcar_pkg::gcd_res_t                gcd_res;

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = idx_r < lcar_pkg::IDX_BITS'(lcar_pkg::MAX_LENGTH);
  assign need_gcd  = in_range && (idx_r != '0);
  assign pos       = idx_r[lcar_pkg::POS_BITS-1:0];
  assign run_len   = pos - cur_start_r;

  // Shared gcd unit, started on the accept of any element that closes a pair.
  lcar_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && need_gcd),
    .op_a  (prev_r),
    .op_b  (in_tdata[lcar_pkg::VALUE_BITS-1:0]),
    .res   (gcd_res)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = need_gcd ? S_GCD : S_UPD;
        end
      end
      S_GCD: begin
        if (gcd_res.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Run search update for the element held in value_r.
  always_comb begin
    prev_nxt       = prev_r;
    idx_nxt        = idx_r;
    cur_start_nxt  = cur_start_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    best_len_nxt   = best_len_r;
    exceeded_nxt   = exceeded_r;
    if (in_range) begin
      if (idx_r != '0) begin
        if (coprime_r) begin
          if (run_len > best_len_r) begin
            best_len_nxt   = run_len;
            best_start_nxt = cur_start_r;
            best_end_nxt   = pos;
          end
        end else begin
          cur_start_nxt = pos;
        end
      end
      prev_nxt = value_r;
      idx_nxt  = idx_r + lcar_pkg::IDX_BITS'(1);
    end else begin
      exceeded_nxt = 1'b1;
    end
  end

  // Control state and run search state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_r       <= '0;
      idx_r        <= '0;
      cur_start_r  <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
      best_len_r   <= '0;
      exceeded_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_UPD) begin
        if (last_r) begin
          // Stream finished: report and start over.
          out_valid_r  <= 1'b1;
          prev_r       <= '0;
          idx_r        <= '0;
          cur_start_r  <= '0;
          best_start_r <= '0;
          best_end_r   <= '0;
          best_len_r   <= '0;
          exceeded_r   <= 1'b0;
        end else begin
          prev_r       <= prev_nxt;
          idx_r        <= idx_nxt;
          cur_start_r  <= cur_start_nxt;
          best_start_r <= best_start_nxt;
          best_end_r   <= best_end_nxt;
          best_len_r   <= best_len_nxt;
          exceeded_r   <= exceeded_nxt;
        end
      end
    end
  end

  // Payload registers: the accepted element, the gcd verdict and the result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r   <= in_tdata[lcar_pkg::VALUE_BITS-1:0];
      last_r    <= in_tlast;
      coprime_r <= 1'b0;
    end else if (state_r == S_GCD && gcd_res.done) begin
      coprime_r <= gcd_res.coprime;
    end
    if (state_r == S_UPD && last_r) begin
      out_start_r <= lcar_pkg::RUN_BITS'(best_start_nxt);
      out_end_r   <= lcar_pkg::RUN_BITS'(best_end_nxt);
      out_ovf_r   <= exceeded_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = lcar_pkg::OUT_TDATA_W'({out_end_r, out_start_r});
  assign out_tuser  = out_ovf_r;

`ifndef NO_ASSERTIONS
  // A recorded best run spans exactly its stored number of pairs.
  assert property (@(posedge clk) disable iff (!rst_n)
    (best_len_r != '0) |-> ((best_end_r - best_start_r) == best_len_r))
    else $error("best run bounds disagree with its length");

  // The present run never starts beyond the next element position.
  assert property (@(posedge clk) disable iff (!rst_n)
    idx_r >= lcar_pkg::IDX_BITS'(cur_start_r))
    else $error("current run start ahead of element index");

  // A result appears only after the update of a final element.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD && last_r))
    else $error("result raised without a final element");

  // The gcd unit finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    gcd_res.done |-> (state_r == S_GCD))
    else $error("gcd finished outside its wait state");
`endif

endmodule

`default_nettype wire

FILE: rtl/lcar_gcd.sv
`default_nettype none

module lcar_gcd (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [lcar_pkg::VALUE_BITS-1:0] op_a,
  input  wire logic [lcar_pkg::VALUE_BITS-1:0] op_b,
  output lcar_pkg::gcd_res_t                  res
);

  // Binary gcd, one reduction step per cycle.
  logic [lcar_pkg::VALUE_BITS-1:0] a_r, a_nxt;
  logic [lcar_pkg::VALUE_BITS-1:0] b_r, b_nxt;
  logic                            twos_r, twos_nxt;
  logic                            busy_r, busy_nxt;
  logic                            zero_hit;

  assign zero_hit = (a_r == '0) || (b_r == '0);

  // The gcd is 1 only if no common factor of two was removed and the survivor is 1.
  assign res.done    = busy_r && zero_hit;
  assign res.coprime = !twos_r && ((a_r | b_r) == lcar_pkg::VALUE_BITS'(1));

  // Next operand values for one step.
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    twos_nxt = twos_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      twos_nxt = 1'b0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (zero_hit) begin
        busy_nxt = 1'b0;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt    = a_r >> 1;
        b_nxt    = b_r >> 1;
        twos_nxt = 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Operand registers.
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    twos_r <= twos_nxt;
  end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int STREAM_ITEMS   = 1650;
  localparam int LONG_AFTER     = 300;

  // One element of a stream and one run report.
  typedef struct packed {
    logic [lcar_pkg::VALUE_BITS-1:0] value;
    logic                            last;
  } stream_elem_t;

  typedef struct packed {
    logic [lcar_pkg::RUN_BITS-1:0] run_start;
    logic [lcar_pkg::RUN_BITS-1:0] run_end;
    logic                          overflow;
  } run_report_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [lcar_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] value
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [lcar_pkg::OUT_TDATA_W-1:0] out_tdata;       // [9:0] run_start, [19:10] run_end
  logic                             out_tuser;       // overflow

  longest_coprime_adjacent_run dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_elem_t elems_to_send[$];
  run_report_t  reports_due[$];
  int           total_elems = 0;
  int           elems_taken = 0;
  int           quiet_cycles = 0;
  int           errors = 0;
  int           late_errors = 0;
  logic         in_took = 1'b0;

  // Run search state of the predictor.
  logic [lcar_pkg::VALUE_BITS-1:0] prior_value = '0;
  int unsigned                     next_pos = 0;
  int unsigned                     open_run_from = 0;
  int unsigned                     longest_from = 0;
  int unsigned                     longest_to = 0;
  int unsigned                     longest_pairs = 0;
  logic                            saw_overflow = 1'b0;

  function automatic int unsigned common_divisor(input int unsigned a, input int unsigned b);
    int unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Advance the run search by one element; a flagged last element closes the stream.
  task automatic track_element(input logic [lcar_pkg::VALUE_BITS-1:0] v, input logic is_last);
    run_report_t rep;
    if (next_pos < lcar_pkg::MAX_LENGTH) begin
      if (next_pos > 0) begin
        if (common_divisor(32'(prior_value), 32'(v)) == 1) begin
          // Only a strictly longer run replaces the earlier best one.
          if (next_pos - open_run_from > longest_pairs) begin
            longest_pairs = next_pos - open_run_from;
            longest_from  = open_run_from;
            longest_to    = next_pos;
          end
        end else begin
          open_run_from = next_pos;
        end
      end
      prior_value = v;
      next_pos++;
    end else begin
      saw_overflow = 1'b1;
    end
    if (is_last) begin
      rep.run_start = longest_from[lcar_pkg::RUN_BITS-1:0];
      rep.run_end   = longest_to[lcar_pkg::RUN_BITS-1:0];
      rep.overflow  = saw_overflow;
      reports_due.push_back(rep);
      prior_value   = '0;
      next_pos      = 0;
      open_run_from = 0;
      longest_from  = 0;
      longest_to    = 0;
      longest_pairs = 0;
      saw_overflow  = 1'b0;
    end
  endtask

  task automatic push_elem(input int unsigned v, input logic is_last);
    stream_elem_t e;
    e.value = v[lcar_pkg::VALUE_BITS-1:0];
    e.last  = is_last;
    elems_to_send.push_back(e);
    total_elems++;
  endtask

  // Mix of zeros, ones, all-ones, small, even, multiples of three and full-range values.
  function automatic logic [lcar_pkg::VALUE_BITS-1:0] pick_value();
    logic [lcar_pkg::VALUE_BITS-1:0] v;
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = lcar_pkg::VALUE_BITS'(1);
      2: v = '1;
      3, 4, 5: v = lcar_pkg::VALUE_BITS'($urandom_range(1, 12));
      6, 7: v = lcar_pkg::VALUE_BITS'({$urandom_range(0, 32767), 1'b0});
      8: v = lcar_pkg::VALUE_BITS'(3 * $urandom_range(1, 21845));
      default: v = lcar_pkg::VALUE_BITS'($urandom_range(1, 65535));
    endcase
    return v;
  endfunction

  // A stream with random content; the leaning kind mostly steps by one to build long runs.
  task automatic queue_stream(input int len, input bit leaning);
    logic [lcar_pkg::VALUE_BITS-1:0] v;
    v = pick_value();
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if (leaning && $urandom_range(0, 3) != 0) v = v + 1'b1;
        else v = pick_value();
      end
      push_elem(32'(v), i == len - 1);
    end
  endtask

  // Stream stimulus driven at the falling edge.
  always @(negedge clk) begin : feed
    stream_elem_t nxt;
    int           phase;
    int           send_idle;
    int           recv_idle;
    phase     = (total_elems > 0) ? elems_taken * 3 / total_elems : 0;
    send_idle = (phase == 0) ? 26 : (phase == 1) ? 56 : 0;
    recv_idle = (phase == 0) ? 56 : (phase == 1) ? 26 : 0;
    if (rst_n) begin
      if (!in_tvalid || in_took) begin
        if (elems_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt = elems_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= lcar_pkg::IN_TDATA_W'(nxt.value);
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Accepted items on both channels, checked at the rising edge.
  always @(posedge clk) begin : observe
    run_report_t seen;
    run_report_t want;
    logic        moved;
    moved = 1'b0;
    if (!rst_n) begin
      in_took      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        track_element(in_tdata[lcar_pkg::VALUE_BITS-1:0], in_tlast);
        elems_taken++;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved          = 1'b1;
        seen.run_start = out_tdata[lcar_pkg::RUN_BITS-1:0];
        seen.run_end   = out_tdata[2*lcar_pkg::RUN_BITS-1:lcar_pkg::RUN_BITS];
        seen.overflow  = out_tuser;
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result start=%0d end=%0d overflow=%0d",
                   $time, seen.run_start, seen.run_end, seen.overflow);
        end else begin
          want = reports_due.pop_front();
          if (seen.run_start !== want.run_start) begin
            errors++;
            $display("%0t: run_start expected %0d actual %0d",
                     $time, want.run_start, seen.run_start);
          end
          if (seen.run_end !== want.run_end) begin
            errors++;
            $display("%0t: run_end expected %0d actual %0d",
                     $time, want.run_end, seen.run_end);
          end
          if (seen.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %0d actual %0d",
                     $time, want.overflow, seen.overflow);
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    int len;
    int short_elems;
    bit long_done;
    short_elems = 0;
    long_done   = 1'b0;

    // Single element reports an empty run.
    push_elem(7, 1'b1);
    // Two zeros have gcd 0, so no coprime pair.
    push_elem(0, 1'b0);
    push_elem(0, 1'b1);
    // A zero next to a one counts as coprime.
    push_elem(0, 1'b0);
    push_elem(1, 1'b0);
    push_elem(0, 1'b1);
    // Largest values.
    push_elem(65535, 1'b0);
    push_elem(65534, 1'b0);
    push_elem(1, 1'b1);
    // Two runs of equal length: the earlier one wins.
    push_elem(6, 1'b0);
    push_elem(4, 1'b0);
    push_elem(9, 1'b0);
    push_elem(8, 1'b0);
    push_elem(6, 1'b0);
    push_elem(35, 1'b0);
    push_elem(12, 1'b1);
    // No coprime pair at all.
    push_elem(2, 1'b0);
    push_elem(4, 1'b0);
    push_elem(8, 1'b1);
    // High single bits.
    push_elem(32768, 1'b0);
    push_elem(16384, 1'b0);
    push_elem(3, 1'b1);
    // Equal ones are coprime.
    push_elem(1, 1'b0);
    push_elem(1, 1'b1);

    // Random streams, with one stream past the depth limit in the middle.
    while (total_elems < STREAM_ITEMS) begin
      if (!long_done && short_elems >= LONG_AFTER) begin
        // Consecutive values are all coprime; the element past the limit is dropped.
        for (int i = 0; i <= lcar_pkg::MAX_LENGTH; i++) begin
          push_elem(i + 2, i == lcar_pkg::MAX_LENGTH);
        end
        long_done = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0: len = $urandom_range(41, 120);
          1, 2, 3, 4, 5: len = $urandom_range(13, 40);
          default: len = $urandom_range(1, 12);
        endcase
        queue_stream(len, $urandom_range(0, 4) < 3);
        short_elems += len;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(elems_taken == total_elems && reports_due.size() == 0) &&
           quiet_cycles < WATCHDOG_LIMIT);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      late_errors++;
      $display("%0t: timeout, %0d of %0d items taken, %0d results outstanding",
               $time, elems_taken, total_elems, reports_due.size());
    end else begin
      // Catch any result that arrives with nothing expected.
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (reports_due.size() != 0) begin
        late_errors++;
        $display("%0t: %0d expected results never arrived", $time, reports_due.size());
      end
    end

    if (errors == 0 && late_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
